// File: hw/rtl/pfhd_pkg.sv
// ----------------------------------------------------------------------------
// Packet field hash demux package
// Shared widths, register indexes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package pfhd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OFFS_W   = 16;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned PORTS_W  = 7;
  localparam int unsigned POS_W    = 17;
  localparam int unsigned SUM_W    = 24;
  localparam int unsigned PORT_W   = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned STEP_W   = 5;

  localparam logic [POS_W-1:0]   POS_MAX   = '1;
  localparam logic [STEP_W-1:0]  DIV_LAST  = STEP_W'(SUM_W - 1);
  localparam logic [PORTS_W-1:0] PORTS_MAX = PORTS_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_OFFSET = 2'd0,
    REG_WINDOW_BYTES  = 2'd1,
    REG_PORT_COUNT    = 2'd2,
    REG_UNUSED        = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic accept;
    logic clear_rem;
    logic div_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fast;
  } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/pfhd_datapath.sv
// ----------------------------------------------------------------------------
// Packet field hash demux datapath
// Configuration registers, window accumulator, bit-serial modulo and result.
// ----------------------------------------------------------------------------
`default_nettype none

module pfhd_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [pfhd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pfhd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic [pfhd_pkg::BYTE_W-1:0]         data_byte,
  input  wire logic                                end_of_packet,
  input  wire pfhd_pkg::ctrl_cmd_t                 cmd,
  output pfhd_pkg::dp_status_t                     status,
  output logic [pfhd_pkg::PORT_W-1:0]              port_number,
  output logic                                     too_short
);

  logic [pfhd_pkg::OFFS_W-1:0]  offset_r;
  logic [pfhd_pkg::CNT_W-1:0]   bytes_r;
  logic [pfhd_pkg::PORTS_W-1:0] ports_r;
  logic [pfhd_pkg::POS_W-1:0]   pos_r;
  logic [pfhd_pkg::SUM_W-1:0]   sum_r;
  logic [pfhd_pkg::SUM_W-1:0]   div_r;
  logic [pfhd_pkg::PORT_W-1:0]  rem_r;
  logic                         short_r;
  logic [pfhd_pkg::PORT_W-1:0]  port_r;
  logic                         too_short_r;

  logic [pfhd_pkg::POS_W-1:0]   win_end;
  logic                         in_win;
  logic [pfhd_pkg::SUM_W-1:0]   sum_nxt;
  logic [pfhd_pkg::POS_W-1:0]   pos_nxt;
  logic [pfhd_pkg::PORTS_W-1:0] eff_n;
  logic                         pow2;
  logic [pfhd_pkg::PORTS_W-1:0] trial;
  logic [pfhd_pkg::PORT_W-1:0]  rem_nxt;
  logic [2:0]                   hash;
  logic [pfhd_pkg::PORT_W-1:0]  result;

  assign win_end = {1'b0, offset_r} + {1'b0, bytes_r};
  assign in_win  = (pos_r >= {1'b0, offset_r}) && (pos_r < win_end);
  assign sum_nxt = sum_r + (in_win ? pfhd_pkg::SUM_W'(data_byte) : '0);
  assign pos_nxt = (pos_r == pfhd_pkg::POS_MAX) ? pos_r : pos_r + 1'b1;

  always_comb begin
    if (ports_r == '0) begin
      eff_n = pfhd_pkg::PORTS_W'(1);
    end else if (ports_r > pfhd_pkg::PORTS_MAX) begin
      eff_n = pfhd_pkg::PORTS_MAX;
    end else begin
      eff_n = ports_r;
    end
  end

  assign pow2 = (eff_n == pfhd_pkg::PORTS_W'(2)) || (eff_n == pfhd_pkg::PORTS_W'(4)) ||
                (eff_n == pfhd_pkg::PORTS_W'(8));

  assign trial   = {rem_r, div_r[pfhd_pkg::SUM_W-1]};
  assign rem_nxt = (trial >= eff_n) ? pfhd_pkg::PORT_W'(trial - eff_n)
                                    : pfhd_pkg::PORT_W'(trial);

  assign hash = (div_r[2:0] ^ div_r[6:4]) & (eff_n[2:0] - 3'd1);

  always_comb begin
    if (short_r) begin
      result = '0;
    end else if (pow2) begin
      result = pfhd_pkg::PORT_W'(hash);
    end else begin
      result = rem_r;
    end
  end

  assign status.fast = short_r || pow2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      bytes_r  <= pfhd_pkg::CNT_W'(1);
      ports_r  <= pfhd_pkg::PORTS_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        pfhd_pkg::REG_WINDOW_OFFSET: offset_r <= cfg_data;
        pfhd_pkg::REG_WINDOW_BYTES:  bytes_r  <= cfg_data;
        pfhd_pkg::REG_PORT_COUNT:    ports_r  <= cfg_data[pfhd_pkg::PORTS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
    end else if (cmd.accept) begin
      if (end_of_packet) begin
        pos_r <= '0;
        sum_r <= '0;
      end else begin
        pos_r <= pos_nxt;
        sum_r <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && end_of_packet) begin
      div_r   <= sum_nxt;
      short_r <= pos_nxt < win_end;
    end else if (cmd.div_step) begin
      div_r <= {div_r[pfhd_pkg::SUM_W-2:0], 1'b0};
    end
    if (cmd.clear_rem) begin
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
    end
    if (cmd.load_out) begin
      port_r      <= result;
      too_short_r <= short_r;
    end
  end

  assign port_number = port_r;
  assign too_short   = too_short_r;

endmodule

`default_nettype wire

// File: hw/rtl/pfhd_ctrl.sv
// ----------------------------------------------------------------------------
// Packet field hash demux controller
// Sequences byte intake, the modulo steps and the output word handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module pfhd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_last,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire pfhd_pkg::dp_status_t status,
  output pfhd_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [3:0] {
    ST_ACCUM  = 4'b0001,
    ST_FINISH = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [pfhd_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_ACCUM);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_ACCUM: begin
        cmd.accept = in_valid;
        if (in_valid && in_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.clear_rem = 1'b1;
        step_nxt      = '0;
        state_nxt     = status.fast ? ST_EMIT : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == pfhd_pkg::DIV_LAST) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_ACCUM;
        end
      end
      default: begin
        state_nxt = ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCUM;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVIDE) |-> (step_r <= pfhd_pkg::DIV_LAST))
    else $error("modulo step counter out of range");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("output word raised outside the emit state");

  a_finish_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACCUM && in_valid && in_last) |=> (state_r == ST_FINISH))
    else $error("last byte did not start result computation");

endmodule

`default_nettype wire

// File: hw/rtl/packet_field_hash_demux.sv
// ----------------------------------------------------------------------------
// Packet field hash demux
// Sums a configured byte window of each packet and picks an output port.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle; the last byte stalls input until its result
// is registered. Short packets and port counts 2, 4 or 8 skip the modulo; all
// others run it one bit per cycle over the 24-bit sum.
// The output word is registered and the next packet is taken while it waits.
// Reset is synchronous, active low, and restores the default configuration.
`default_nettype none

module packet_field_hash_demux (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [7:0]                        in_tdata,  // data_byte
  input  wire logic                              in_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [7:0]                             out_tdata, // port_number, zero pad
  output logic                                   out_tuser, // too_short
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [pfhd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pfhd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pfhd_pkg::ctrl_cmd_t          cmd;
  pfhd_pkg::dp_status_t         status;
  logic [pfhd_pkg::PORT_W-1:0]  port_number;

  assign cfg_ready = 1'b1;
  assign out_tdata = 8'(port_number);

  pfhd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_last   (in_tlast),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .status    (status),
    .cmd       (cmd)
  );

  pfhd_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .data_byte     (in_tdata),
    .end_of_packet (in_tlast),
    .cmd           (cmd),
    .status        (status),
    .port_number   (port_number),
    .too_short     (out_tuser)
  );

endmodule

`default_nettype wire
